/* rtl/smb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smb_pkg
// Shared widths, request and register codes, and reset values for the
// step/direction generator with backlash compensation.
// ----------------------------------------------------------------------------
package smb_pkg;

    // default parameter values
    localparam int POSITION_BITS_DEF = 32;
    localparam int BACKLASH_BITS_DEF = 16;

    // fixed field widths
    localparam int REQ_BITS      = 3;
    localparam int FIELD_POS_W   = 32;
    localparam int FIELD_BL_W    = 16;
    localparam int RPM_W         = 12;
    localparam int FSTEPS_W      = 10;
    localparam int USTEP_W       = 9;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 12;
    localparam int TICK_BITS     = 17;
    localparam int PROD1_W       = RPM_W + FSTEPS_W;
    localparam int PROD_W        = PROD1_W + USTEP_W;

    // step period = PERIOD_BASE / product, at least PERIOD_MIN
    localparam int PERIOD_BASE   = 60000;
    localparam int PERIOD_MIN    = 1;
    localparam int QUOT_W        = 16;
    localparam int DIV_CNT_W     = 4;

    // request codes
    localparam logic [REQ_BITS-1:0] REQ_TICK      = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_REL_MOVE  = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_ABS_MOVE  = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_STOP      = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_RESET_POS = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RPM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FSTEPS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USTEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 3'd3;

    // register reset values
    localparam logic [RPM_W-1:0]    RPM_RST    = 12'd0;
    localparam logic [FSTEPS_W-1:0] FSTEPS_RST = 10'd200;
    localparam logic [USTEP_W-1:0]  USTEP_RST  = 9'd16;
    localparam logic                HOLD_RST   = 1'b1;

endpackage : smb_pkg
`default_nettype wire

/* rtl/smb_cmd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smb_cmd_if
// Command channel: one word is one request with its move fields.
// ----------------------------------------------------------------------------
interface smb_cmd_if;
    import smb_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [REQ_BITS-1:0]           req_type;
    logic signed [FIELD_POS_W-1:0] step_count;
    logic [FIELD_BL_W-1:0]         backlash_count;
    logic signed [FIELD_POS_W-1:0] goal_position;

    modport source (
        output valid, req_type, step_count, backlash_count, goal_position,
        input  ready
    );
    modport sink (
        input  valid, req_type, step_count, backlash_count, goal_position,
        output ready
    );
endinterface : smb_cmd_if
`default_nettype wire

/* rtl/smb_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smb_res_if
// Result channel: one word per command with the pin levels and position.
// ----------------------------------------------------------------------------
interface smb_res_if;
    import smb_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          step_pulse;
    logic                          dir_cw;
    logic                          motor_enable;
    logic                          moving;
    logic signed [FIELD_POS_W-1:0] user_position;

    modport source (
        output valid, step_pulse, dir_cw, motor_enable, moving, user_position,
        input  ready
    );
    modport sink (
        input  valid, step_pulse, dir_cw, motor_enable, moving, user_position,
        output ready
    );
endinterface : smb_res_if
`default_nettype wire

/* rtl/smb_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smb_cfg_if
// Configuration write channel: one word is a register index and its data.
// ----------------------------------------------------------------------------
interface smb_cfg_if;
    import smb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface : smb_cfg_if
`default_nettype wire

/* rtl/stepper_motion_backlash_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_motion_backlash_core
// Step/direction generator with backlash compensation on direction reversal.
// ----------------------------------------------------------------------------
// One command word is taken per clock and each gives one result word in the
// next cycle through an output register, so ticks and moves stream at one word per
// cycle while the result side keeps taking. A configuration write is taken in
// any cycle and starts a recompute of the step period: two registered multiply
// steps and a shift-subtract divide of 60000 by the speed product, during which
// command words are held off (no divide when the product is zero). Positions
// wrap at POSITION_BITS and the reported logical position is that value
// sign-extended or cut to 32 bits.
// ----------------------------------------------------------------------------
module stepper_motion_backlash_core
    import smb_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int BACKLASH_BITS = BACKLASH_BITS_DEF
)
(
    input  wire       clk,
    input  wire       rst_n,
    smb_cmd_if.sink   cmd,
    smb_res_if.source res,
    smb_cfg_if.sink   cfg
);

    localparam int P = POSITION_BITS;
    localparam int B = BACKLASH_BITS;

    // recompute sequencer codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL1 = 2'd1;
    localparam logic [1:0] PH_MUL2 = 2'd2;
    localparam logic [1:0] PH_DIV  = 2'd3;

    // configuration registers
    logic [RPM_W-1:0]    rpm_reg;
    logic [FSTEPS_W-1:0] fsteps_reg;
    logic [USTEP_W-1:0]  ustep_reg;
    logic                hold_reg;

    // period recompute
    logic [1:0]           phase_reg, phase_next;
    logic [PROD1_W-1:0]   prod1_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [QUOT_W-1:0]    dvd_reg;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TICK_BITS-1:0] period_reg;
    logic [PROD_W:0]      trial;
    logic                 trial_ge;

    // motion state
    logic                 running_reg, running_next;
    logic                 dir_reg, dir_next;
    logic                 enable_reg, enable_next;
    logic [P-1:0]         phys_reg, phys_next;
    logic [P-1:0]         target_reg, target_next;
    logic [P-1:0]         logical_reg, logical_next;
    logic [B-1:0]         bl_left_reg, bl_left_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic                 pulse;

    // result register
    logic                 res_valid_reg;
    logic                 res_pulse_reg;
    logic                 res_dir_reg;
    logic                 res_enable_reg;
    logic                 res_moving_reg;
    logic [FIELD_POS_W-1:0] res_pos_reg;

    logic                 cmd_fire;
    logic                 cfg_fire;

    // move helpers
    logic [P-1:0]         move_delta;
    logic [B-1:0]         move_bl;
    logic                 move_cw;
    logic [P-1:0]         move_adj;
    logic [TICK_BITS-1:0] tick_inc;
    logic                 step_up;

    // handshakes
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;
    assign cmd.ready = (phase_reg == PH_IDLE) && (!res_valid_reg || res.ready);
    assign cmd_fire  = cmd.valid && cmd.ready;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_reg    <= RPM_RST;
            fsteps_reg <= FSTEPS_RST;
            ustep_reg  <= USTEP_RST;
            hold_reg   <= HOLD_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg.index)
                CFG_RPM:    rpm_reg    <= cfg.data[RPM_W-1:0];
                CFG_FSTEPS: fsteps_reg <= cfg.data[FSTEPS_W-1:0];
                CFG_USTEP:  ustep_reg  <= cfg.data[USTEP_W-1:0];
                CFG_HOLD:   hold_reg   <= cfg.data[0];
                default:    ;
            endcase
        end
    end

    // one shift-subtract divide step
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[QUOT_W-1]};
        trial_ge  = trial >= {1'b0, prod_reg};
        rem_next  = trial_ge ? PROD_W'(trial - {1'b0, prod_reg}) : trial[PROD_W-1:0];
        quot_next = {quot_reg[QUOT_W-2:0], trial_ge};
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: phase_next = PH_IDLE;
            PH_MUL1: phase_next = PH_MUL2;
            PH_MUL2: phase_next = (prod1_reg == '0 || ustep_reg == '0) ? PH_IDLE : PH_DIV;
            PH_DIV:  phase_next = (cnt_reg == DIV_CNT_W'(QUOT_W - 1)) ? PH_IDLE : PH_DIV;
            default: phase_next = PH_IDLE;
        endcase
        if (cfg_fire)
            phase_next = PH_MUL1;
    end

    // period recompute sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            prod1_reg  <= '0;
            prod_reg   <= '0;
            rem_reg    <= '0;
            dvd_reg    <= '0;
            quot_reg   <= '0;
            cnt_reg    <= '0;
            period_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            unique case (phase_reg)
                PH_MUL1:
                begin
                    prod1_reg <= rpm_reg * fsteps_reg;
                end
                PH_MUL2:
                begin
                    prod_reg <= prod1_reg * ustep_reg;
                    rem_reg  <= '0;
                    dvd_reg  <= QUOT_W'(PERIOD_BASE);
                    quot_reg <= '0;
                    cnt_reg  <= '0;
                    if (prod1_reg == '0 || ustep_reg == '0)
                        period_reg <= '0;
                end
                PH_DIV:
                begin
                    rem_reg  <= rem_next;
                    dvd_reg  <= {dvd_reg[QUOT_W-2:0], 1'b0};
                    quot_reg <= quot_next;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_CNT_W'(QUOT_W - 1))
                        period_reg <= (quot_next == '0) ? TICK_BITS'(PERIOD_MIN)
                                                        : TICK_BITS'(quot_next);
                end
                default: ;
            endcase
        end
    end

    // move set-up: delta, backlash and direction
    always_comb
    begin
        if (cmd.req_type == REQ_ABS_MOVE)
        begin
            move_delta = P'(cmd.goal_position) - logical_reg;
            move_bl    = '0;
        end
        else
        begin
            move_delta = P'(cmd.step_count);
            move_bl    = B'(cmd.backlash_count);
        end
        move_cw  = !move_delta[P-1];
        move_adj = move_cw ? move_delta + P'(move_bl) : move_delta - P'(move_bl);
        tick_inc = tick_reg + 1'b1;
        step_up  = $signed(phys_reg) < $signed(target_reg);
    end

    // command decode and state update
    always_comb
    begin
        running_next = running_reg;
        dir_next     = dir_reg;
        enable_next  = enable_reg;
        phys_next    = phys_reg;
        target_next  = target_reg;
        logical_next = logical_reg;
        bl_left_next = bl_left_reg;
        tick_next    = tick_reg;
        pulse        = 1'b0;
        unique case (cmd.req_type)
            REQ_TICK:
            begin
                if (running_reg)
                begin
                    if (phys_reg == target_reg)
                    begin
                        running_next = 1'b0;
                        if (!hold_reg)
                            enable_next = 1'b0;
                    end
                    else if (period_reg != '0)
                    begin
                        if (tick_inc < period_reg)
                            tick_next = tick_inc;
                        else
                        begin
                            tick_next = '0;
                            pulse     = 1'b1;
                            dir_next  = step_up;
                            phys_next = step_up ? phys_reg + 1'b1 : phys_reg - 1'b1;
                            if (bl_left_reg != '0)
                                bl_left_next = bl_left_reg - 1'b1;
                            else
                                logical_next = step_up ? logical_reg + 1'b1
                                                       : logical_reg - 1'b1;
                        end
                    end
                end
            end
            REQ_REL_MOVE, REQ_ABS_MOVE:
            begin
                if (move_delta != '0)
                begin
                    if (move_bl != '0 && move_cw != dir_reg)
                    begin
                        bl_left_next = move_bl;
                        target_next  = phys_reg + move_adj;
                    end
                    else
                    begin
                        bl_left_next = '0;
                        target_next  = phys_reg + move_delta;
                    end
                    dir_next     = move_cw;
                    tick_next    = period_reg;
                    running_next = 1'b1;
                    enable_next  = 1'b1;
                end
            end
            REQ_STOP:
            begin
                target_next  = phys_reg;
                running_next = 1'b0;
                if (!hold_reg)
                    enable_next = 1'b0;
            end
            REQ_RESET_POS:
            begin
                phys_next    = '0;
                target_next  = '0;
                logical_next = '0;
                bl_left_next = '0;
            end
            default: ;
        endcase
    end

    // motion state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            dir_reg     <= 1'b1;
            enable_reg  <= HOLD_RST;
            phys_reg    <= '0;
            target_reg  <= '0;
            logical_reg <= '0;
            bl_left_reg <= '0;
            tick_reg    <= '0;
        end
        else if (cmd_fire)
        begin
            running_reg <= running_next;
            dir_reg     <= dir_next;
            enable_reg  <= enable_next;
            phys_reg    <= phys_next;
            target_reg  <= target_next;
            logical_reg <= logical_next;
            bl_left_reg <= bl_left_next;
            tick_reg    <= tick_next;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd_fire)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            res_pulse_reg  <= pulse;
            res_dir_reg    <= dir_next;
            res_enable_reg <= enable_next;
            res_moving_reg <= running_next;
            res_pos_reg    <= FIELD_POS_W'($signed(logical_next));
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.step_pulse    = res_pulse_reg;
    assign res.dir_cw        = res_dir_reg;
    assign res.motor_enable  = res_enable_reg;
    assign res.moving        = res_moving_reg;
    assign res.user_position = res_pos_reg;

    // checks
    a_run_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> enable_reg)
        else $error("move running with driver disabled");

    a_pulse_moving: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_pulse_reg |-> res_moving_reg)
        else $error("step issued outside a running move");

    a_hold_off: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |-> !cmd.ready)
        else $error("command taken during period recompute");

    a_period_set: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE && prod_reg != '0 |-> period_reg != '0)
        else $error("no-step period with nonzero speed product");

endmodule : stepper_motion_backlash_core
`default_nettype wire

/* verif/tb_stepper_motion_backlash_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_motion_backlash_core
// Self-checking bench for the step/direction generator with backlash. Command
// words stream in under random valid and ready gaps. Each word is predicted
// from a local model of the axis, and each result word is compared field by
// field in order. Speed and hold settings change between phases while idle.
// ----------------------------------------------------------------------------
module tb_stepper_motion_backlash_core;
    import smb_pkg::*;

    // request codes the block must ignore
    localparam logic [REQ_BITS-1:0] REQ_FIRST_UNUSED = 3'd5;
    localparam logic [REQ_BITS-1:0] REQ_MAX_CODE     = 3'd7;

    localparam int     HOLD_OFF_CYCLES = 120;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     PRINT_CAP       = 40;
    localparam int     RANDOM_PHASES   = 10;
    localparam int     PHASE_WORDS     = 145;
    localparam int     SLOW_WORDS      = 60;
    localparam longint TIMEOUT_NS      = 6_000_000;

    typedef struct packed {
        logic [REQ_BITS-1:0]    req;
        logic [FIELD_POS_W-1:0] steps;
        logic [FIELD_BL_W-1:0]  backlash;
        logic [FIELD_POS_W-1:0] goal;
    } cmd_word_t;

    typedef struct packed {
        logic                   pulse;
        logic                   dir_cw;
        logic                   enable;
        logic                   moving;
        logic [FIELD_POS_W-1:0] position;
    } pin_word_t;

    logic clk;
    logic rst_n;

    smb_cmd_if cmd_bus ();
    smb_res_if res_bus ();
    smb_cfg_if cfg_bus ();

    stepper_motion_backlash_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // stimulus and expectation stores
    cmd_word_t cmd_backlog[$];
    pin_word_t expected_pins[$];
    int        planned_items;
    int        mismatch_count;
    bit        hold_off_request;
    bit        hold_off_done;

    // axis model: settings and state
    logic [RPM_W-1:0]       set_rpm;
    logic [FSTEPS_W-1:0]    set_fsteps;
    logic [USTEP_W-1:0]     set_ustep;
    logic                   set_hold;
    logic                   axis_running;
    logic                   axis_dir;
    logic                   axis_enable;
    logic [FIELD_POS_W-1:0] axis_phys;
    logic [FIELD_POS_W-1:0] axis_target;
    logic [FIELD_POS_W-1:0] axis_logical;
    logic [FIELD_BL_W-1:0]  axis_backlash;
    logic [TICK_BITS-1:0]   axis_tick;
    logic [TICK_BITS-1:0]   axis_period;

    // driver and receiver pacing
    cmd_word_t drv_taken;
    cmd_word_t drv_next;
    pin_word_t mon_want;
    int        src_gap;
    int        src_burst;
    int        snk_left;
    int        snk_burst;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // ticks between steps for a speed setting, zero when no steps can issue
    function automatic logic [TICK_BITS-1:0] speed_to_period(input logic [RPM_W-1:0] r,
                                                             input logic [FSTEPS_W-1:0] f,
                                                             input logic [USTEP_W-1:0] u);
        longint unsigned prod;
        longint unsigned quot;
        prod = r;
        prod = prod * f * u;
        if (prod == 0)
            return '0;
        quot = PERIOD_BASE / prod;
        if (quot < PERIOD_MIN)
            quot = PERIOD_MIN;
        return quot[TICK_BITS-1:0];
    endfunction

    function automatic void settle_idle();
        axis_running = 1'b0;
        if (!set_hold)
            axis_enable = 1'b0;
    endfunction

    // load a new target; a reversal adds the backlash to the travel
    function automatic void begin_move(input logic [FIELD_POS_W-1:0] delta,
                                       input logic [FIELD_BL_W-1:0] bl);
        logic cw;
        if (delta == '0)
            return;
        cw = ~delta[FIELD_POS_W-1];
        if (bl != '0 && cw != axis_dir)
        begin
            axis_backlash = bl;
            delta = cw ? delta + bl : delta - bl;
        end
        else
            axis_backlash = '0;
        axis_target  = axis_phys + delta;
        axis_dir     = cw;
        axis_tick    = axis_period;
        axis_running = 1'b1;
        axis_enable  = 1'b1;
    endfunction

    // one tick of the pacing counter, returns the step pulse
    function automatic logic advance_tick();
        logic up;
        if (!axis_running)
            return 1'b0;
        if (axis_phys == axis_target)
        begin
            settle_idle();
            return 1'b0;
        end
        if (axis_period == '0)
            return 1'b0;
        axis_tick = axis_tick + 1'b1;
        if (axis_tick < axis_period)
            return 1'b0;
        axis_tick = '0;
        up        = $signed(axis_phys) < $signed(axis_target);
        axis_dir  = up;
        axis_phys = up ? axis_phys + 1 : axis_phys - 1;
        if (axis_backlash != '0)
            axis_backlash = axis_backlash - 1'b1;
        else
            axis_logical = up ? axis_logical + 1 : axis_logical - 1;
        return 1'b1;
    endfunction

    // apply one command word to the axis and give its result word
    function automatic pin_word_t motion_step(input cmd_word_t w);
        pin_word_t o;
        o.pulse = 1'b0;
        case (w.req)
            REQ_TICK:     o.pulse = advance_tick();
            REQ_REL_MOVE: begin_move(w.steps, w.backlash);
            REQ_ABS_MOVE: begin_move(w.goal - axis_logical, '0);
            REQ_STOP:
            begin
                axis_target = axis_phys;
                settle_idle();
            end
            REQ_RESET_POS:
            begin
                axis_phys     = '0;
                axis_target   = '0;
                axis_logical  = '0;
                axis_backlash = '0;
            end
            default: ;
        endcase
        o.dir_cw   = axis_dir;
        o.enable   = axis_enable;
        o.moving   = axis_running;
        o.position = axis_logical;
        return o;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void add_cmd(input int req,
                                    input logic [FIELD_POS_W-1:0] steps,
                                    input int bl,
                                    input logic [FIELD_POS_W-1:0] goal);
        cmd_word_t w;
        w.req      = REQ_BITS'(req);
        w.steps    = steps;
        w.backlash = FIELD_BL_W'(bl);
        w.goal     = goal;
        cmd_backlog.push_back(w);
        planned_items++;
    endfunction

    function automatic void add_ticks(input int n);
        repeat (n) add_cmd(REQ_TICK, $urandom, $urandom, $urandom);
    endfunction

    // ticks enough to cover a travel at this period, capped when slow
    function automatic int tick_budget(input int travel, input int unsigned period);
        if (period == 0)
            return $urandom_range(1, 6);
        if (period > 8)
            return $urandom_range(1, 20);
        return travel * period + $urandom_range(0, 3);
    endfunction

    // one random sequence of command words
    function automatic void plan_sequence(input int unsigned period);
        int                     kind;
        int                     r;
        int                     n;
        int                     bl;
        int                     ticks;
        logic [FIELD_POS_W-1:0] steps;
        kind  = $urandom_range(0, 99);
        n     = $urandom_range(1, 12);
        steps = $urandom_range(0, 1) ? -n : n;
        r     = $urandom_range(0, 99);
        bl    = (r < 60) ? 0 : ((r < 95) ? $urandom_range(1, 5) : $urandom_range(0, 65535));
        if (kind < 50)
        begin
            // relative move run to its end, sometimes cut short
            add_cmd(REQ_REL_MOVE, steps, bl, $urandom);
            ticks = tick_budget(n + ((bl <= 5) ? bl : 0), period);
            if ($urandom_range(0, 4) == 0)
                ticks = $urandom_range(0, ticks);
            add_ticks(ticks);
            if (bl > 5)
                add_cmd(REQ_STOP, $urandom, $urandom, $urandom);
        end
        else if (kind < 70)
        begin
            // absolute move near home
            if ($urandom_range(0, 2) == 0)
                add_cmd(REQ_RESET_POS, $urandom, $urandom, $urandom);
            add_cmd(REQ_ABS_MOVE, $urandom, $urandom, $urandom_range(0, 30) - 15);
            add_ticks(tick_budget(16, period));
        end
        else if (kind < 80)
        begin
            // stop in the middle of a move
            add_cmd(REQ_REL_MOVE, steps, bl, $urandom);
            add_ticks((period != 0 && period <= 8) ? $urandom_range(0, n * period)
                                                   : $urandom_range(0, 5));
            add_cmd(REQ_STOP, $urandom, $urandom, $urandom);
            add_ticks($urandom_range(1, 3));
        end
        else if (kind < 88)
        begin
            // position reset in the middle of a move
            add_cmd(REQ_REL_MOVE, steps, bl, $urandom);
            add_ticks($urandom_range(0, 4));
            add_cmd(REQ_RESET_POS, $urandom, $urandom, $urandom);
            add_ticks(2);
        end
        else if (kind < 94)
        begin
            // any code with full-range fields
            add_cmd($urandom_range(0, REQ_MAX_CODE), $urandom, $urandom_range(0, 65535),
                    $urandom);
            add_ticks($urandom_range(0, 4));
            if ($urandom_range(0, 1) == 0)
                add_cmd(REQ_STOP, $urandom, $urandom, $urandom);
        end
        else
        begin
            // stray stops, resets, unused codes and bare ticks
            repeat ($urandom_range(1, 4))
                add_cmd($urandom_range(REQ_STOP, REQ_MAX_CODE), $urandom, $urandom, $urandom);
            add_ticks($urandom_range(0, 3));
        end
    endfunction

    // wait until every word is sent and every result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_bus.valid || expected_pins.size() != 0);
    endtask

    // one register write; called at a rising edge, valid left high
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            CFG_RPM:    set_rpm    = value[RPM_W-1:0];
            CFG_FSTEPS: set_fsteps = value[FSTEPS_W-1:0];
            CFG_USTEP:  set_ustep  = value[USTEP_W-1:0];
            CFG_HOLD:   set_hold   = value[0];
            default: ;
        endcase
        axis_period = speed_to_period(set_rpm, set_fsteps, set_ustep);
    endtask

    task automatic apply_settings(input logic [RPM_W-1:0] r, input logic [FSTEPS_W-1:0] f,
                                  input logic [USTEP_W-1:0] u, input logic h);
        @(posedge clk);
        write_setting(CFG_RPM, r);
        write_setting(CFG_FSTEPS, f);
        write_setting(CFG_USTEP, u);
        write_setting(CFG_HOLD, h);
        cfg_bus.valid <= 1'b0;
    endtask

    // one random phase: settle, reprogram, queue the words
    task automatic run_phase(input logic [RPM_W-1:0] r, input logic [FSTEPS_W-1:0] f,
                             input logic [USTEP_W-1:0] u, input logic h, input int quota);
        int unsigned period;
        int          first;
        wait_drained();
        apply_settings(r, f, u, h);
        period = speed_to_period(r, f, u);
        @(negedge clk);
        first = planned_items;
        while (planned_items - first < quota)
            plan_sequence(period);
        if (!hold_off_done)
        begin
            hold_off_done    = 1'b1;
            hold_off_request = 1'b1;
        end
    endtask

    // command driver: feeds the backlog and models each accepted word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid          <= 1'b0;
            cmd_bus.req_type       <= REQ_TICK;
            cmd_bus.step_count     <= '0;
            cmd_bus.backlash_count <= '0;
            cmd_bus.goal_position  <= '0;
            src_gap   = 0;
            src_burst = 0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                drv_taken.req      = cmd_bus.req_type;
                drv_taken.steps    = cmd_bus.step_count;
                drv_taken.backlash = cmd_bus.backlash_count;
                drv_taken.goal     = cmd_bus.goal_position;
                expected_pins.push_back(motion_step(drv_taken));
            end
            // offer the next word once the current one has gone
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    cmd_bus.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    drv_next = cmd_backlog.pop_front();
                    cmd_bus.req_type       <= drv_next.req;
                    cmd_bus.step_count     <= drv_next.steps;
                    cmd_bus.backlash_count <= drv_next.backlash;
                    cmd_bus.goal_position  <= drv_next.goal;
                    cmd_bus.valid          <= 1'b1;
                    if (src_burst > 0)
                        src_burst--;
                    else
                    begin
                        src_gap = pick_gap();
                        if ($urandom_range(0, 19) == 0)
                            src_burst = $urandom_range(20, 80);
                    end
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver pacing
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
            snk_left  = 0;
            snk_burst = 0;
        end
        else
        begin
            // compare against the oldest prediction
            if (res_bus.valid && res_bus.ready)
            begin
                if (expected_pins.size() == 0)
                    report_mismatch("word with nothing pending", res_bus.user_position, '0);
                else
                begin
                    mon_want = expected_pins.pop_front();
                    if (res_bus.step_pulse !== mon_want.pulse)
                        report_mismatch("step_pulse", res_bus.step_pulse, mon_want.pulse);
                    if (res_bus.dir_cw !== mon_want.dir_cw)
                        report_mismatch("dir_cw", res_bus.dir_cw, mon_want.dir_cw);
                    if (res_bus.motor_enable !== mon_want.enable)
                        report_mismatch("motor_enable", res_bus.motor_enable, mon_want.enable);
                    if (res_bus.moving !== mon_want.moving)
                        report_mismatch("moving", res_bus.moving, mon_want.moving);
                    if (res_bus.user_position !== mon_want.position)
                        report_mismatch("user_position", res_bus.user_position,
                                        mon_want.position);
                end
            end
            // ready: long hold-off on request, else random runs
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                snk_left = HOLD_OFF_CYCLES;
                res_bus.ready <= 1'b0;
            end
            else if (snk_left > 0)
                snk_left--;
            else if (!res_bus.ready)
            begin
                res_bus.ready <= 1'b1;
                snk_left = $urandom_range(0, 39);
            end
            else if (snk_burst > 0)
                snk_burst--;
            else
            begin
                snk_left = pick_gap();
                if (snk_left > 0)
                begin
                    res_bus.ready <= 1'b0;
                    snk_left--;
                end
                else
                    snk_left = $urandom_range(0, 39);
                if ($urandom_range(0, 19) == 0)
                    snk_burst = $urandom_range(20, 80);
            end
        end
    end

    // reset, directed words, random phases, final verdict
    initial
    begin
        int p;
        rst_n                  = 1'b0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.req_type       = REQ_TICK;
        cmd_bus.step_count     = '0;
        cmd_bus.backlash_count = '0;
        cmd_bus.goal_position  = '0;
        res_bus.ready          = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = CFG_RPM;
        cfg_bus.data           = '0;
        planned_items          = 0;
        mismatch_count         = 0;
        hold_off_request       = 1'b0;
        hold_off_done          = 1'b0;
        set_rpm                = RPM_RST;
        set_fsteps             = FSTEPS_RST;
        set_ustep              = USTEP_RST;
        set_hold               = HOLD_RST;
        axis_running           = 1'b0;
        axis_dir               = 1'b1;
        axis_enable            = HOLD_RST;
        axis_phys              = '0;
        axis_target            = '0;
        axis_logical           = '0;
        axis_backlash          = '0;
        axis_tick              = '0;
        axis_period            = speed_to_period(RPM_RST, FSTEPS_RST, USTEP_RST);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings give no steps: moves run but never advance
        add_cmd(REQ_REL_MOVE, 3, 0, '0);
        add_cmd(REQ_TICK, '0, '0, '0);
        add_cmd(REQ_STOP, '0, '0, '0);
        add_cmd(REQ_FIRST_UNUSED, '0, '0, '0);
        add_cmd(REQ_REL_MOVE, -4, 9, '0);
        add_cmd(REQ_TICK, '0, '0, '0);
        add_cmd(REQ_RESET_POS, '0, '0, '0);
        add_cmd(REQ_TICK, '0, '0, '0);

        // one tick per step, enable drops when idle
        wait_drained();
        apply_settings(12'd75, 10'd200, 9'd4, 1'b0);
        @(negedge clk);
        add_cmd(REQ_REL_MOVE, 2, 3, '0);
        add_ticks(6);
        add_cmd(REQ_REL_MOVE, -1, 0, '0);
        add_cmd(REQ_TICK, '0, '0, '0);
        add_cmd(REQ_REL_MOVE, 0, 16'hFFFF, '0);
        add_cmd(REQ_ABS_MOVE, '0, '0, 1);
        add_cmd(REQ_ABS_MOVE, '0, '0, 32'h7FFF_FFFF);
        add_ticks(2);
        add_cmd(REQ_STOP, '0, '0, '0);
        add_cmd(REQ_REL_MOVE, 32'h8000_0000, 16'hFFFF, '0);
        add_cmd(REQ_TICK, '0, '0, '0);
        add_cmd(REQ_RESET_POS, '0, '0, '0);
        add_cmd(REQ_TICK, '0, '0, '0);

        // random phases over speed and hold settings
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: run_phase(12'd4095, 10'd1023, 9'd256, 1'b1, PHASE_WORDS);
                1: run_phase(12'd1, 10'd1, 9'd1, 1'b0, SLOW_WORDS);
                2: run_phase(12'd300, 10'd0, 9'd16, 1'b1, SLOW_WORDS);
                3: run_phase(12'd4095, 10'd200, 9'd0, 1'b0, SLOW_WORDS);
                4: run_phase(12'd60, 10'd200, 9'd1, 1'($urandom_range(0, 1)), PHASE_WORDS);
                5: run_phase(12'd30, 10'd200, 9'd4, 1'($urandom_range(0, 1)), PHASE_WORDS);
                6: run_phase(12'd20, 10'd200, 9'd5, 1'($urandom_range(0, 1)), PHASE_WORDS);
                7: run_phase(12'd25, 10'd200, 9'd3, 1'($urandom_range(0, 1)), PHASE_WORDS);
                8: run_phase(RPM_W'($urandom_range(0, 4095)),
                             FSTEPS_W'($urandom_range(0, 1023)),
                             USTEP_W'($urandom_range(0, 256)),
                             1'($urandom_range(0, 1)), PHASE_WORDS);
                default: run_phase(12'd100, 10'd200, 9'd16, 1'($urandom_range(0, 1)),
                                   PHASE_WORDS);
            endcase
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_pins.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/smb_pkg.sv
rtl/smb_cmd_if.sv
rtl/smb_res_if.sv
rtl/smb_cfg_if.sv
rtl/stepper_motion_backlash_core.sv
verif/tb_stepper_motion_backlash_core.sv
